@@ hw/rtl/dfrl_pkg.sv @@
// Shared constants, types and helpers for the dated rate floor lookup.
package dfrl_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 7;
    localparam int DAY_W   = 7;
    localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;
    localparam int AMT_W   = 27;
    localparam int RATE_W  = 40;
    localparam int PROD_W  = 50;
    localparam int FRAC_W  = 16;
    localparam int RATE_HI_W = RATE_W - FRAC_W;
    localparam int MAG_W   = AMT_W - 1;

    localparam logic [YEAR_W-1:0]  MIN_YEAR   = YEAR_W'(2009);
    localparam logic [MONTH_W-1:0] LAST_MONTH = MONTH_W'(12);
    localparam logic [MAG_W-1:0]   MAX_AMOUNT = MAG_W'(1000 * 65536);

    // year / 100 as (year * DIV100_MUL) >> DIV100_SHIFT, exact for 14-bit years
    localparam int DIV100_MUL_W = 13;
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = DIV100_MUL_W'(5243);
    localparam int DIV100_SHIFT = 19;
    localparam int DIV100_Q_W   = YEAR_W + DIV100_MUL_W - DIV100_SHIFT;

    localparam logic [MONTH_W-1:0] M_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] M_APR = MONTH_W'(4);
    localparam logic [MONTH_W-1:0] M_JUN = MONTH_W'(6);
    localparam logic [MONTH_W-1:0] M_SEP = MONTH_W'(9);
    localparam logic [MONTH_W-1:0] M_NOV = MONTH_W'(11);

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_DATE   = 3'd1,
        ST_NEG_AMOUNT = 3'd2,
        ST_BIG_AMOUNT = 3'd3,
        ST_FULL       = 3'd4
    } t_status;

    typedef enum logic {
        FN_LOAD  = 1'b0,
        FN_QUERY = 1'b1
    } t_func;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_POST,
        S_RATE,
        S_MUL,
        S_SHIFT,
        S_INSERT,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        MS_LO,
        MS_HI,
        MS_SUM
    } t_mul_step;

    function automatic logic [4:0] month_days(input logic [MONTH_W-1:0] month,
                                              input logic leap);
        logic [4:0] days;
        days = 5'd31;
        if (month == M_FEB) begin
            days = leap ? 5'd29 : 5'd28;
        end else if (month == M_APR || month == M_JUN || month == M_SEP
                     || month == M_NOV) begin
            days = 5'd30;
        end
        return days;
    endfunction

endpackage

@@ hw/rtl/dfrl_ram.sv @@
// Simple dual-port RAM with one write port and one registered read port.
module dfrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/dfrl_date_check.sv @@
// Query validation: Gregorian date check and amount range check.
module dfrl_date_check
    import dfrl_pkg::*;
(
    input  logic [YEAR_W-1:0]  i_year,
    input  logic [MONTH_W-1:0] i_month,
    input  logic [DAY_W-1:0]   i_day,
    input  logic [AMT_W-1:0]   i_amount,
    output t_status            o_status
);

    logic [YEAR_W+DIV100_MUL_W-1:0] q_prod;
    logic [DIV100_Q_W-1:0]          q;
    logic [YEAR_W-1:0]              q_times;
    logic                           div4;
    logic                           div100;
    logic                           div400;
    logic                           leap;
    logic [4:0]                     mlen;
    logic                           date_good;
    logic                           neg;
    logic                           big;

    always_comb begin
        q_prod  = (YEAR_W + DIV100_MUL_W)'(i_year) * (YEAR_W + DIV100_MUL_W)'(DIV100_MUL);
        q       = q_prod[YEAR_W+DIV100_MUL_W-1:DIV100_SHIFT];
        // q * 100 = q * 64 + q * 32 + q * 4
        q_times = (YEAR_W'(q) << 6) + (YEAR_W'(q) << 5) + (YEAR_W'(q) << 2);
        div4    = (i_year[1:0] == 2'b00);
        div100  = (q_times == i_year);
        div400  = div100 && (q[1:0] == 2'b00);
        leap    = (div4 && !div100) || div400;
        mlen    = month_days(i_month, leap);

        date_good = (i_year >= MIN_YEAR) && (i_month != '0) && (i_month <= LAST_MONTH)
                    && (i_day != '0) && (i_day <= DAY_W'(mlen));

        neg = i_amount[AMT_W-1];
        big = !neg && (i_amount[MAG_W-1:0] > MAX_AMOUNT);

        priority if (!date_good) begin
            o_status = ST_BAD_DATE;
        end else if (neg) begin
            o_status = ST_NEG_AMOUNT;
        end else if (big) begin
            o_status = ST_BIG_AMOUNT;
        end else begin
            o_status = ST_OK;
        end
    end

endmodule

@@ hw/rtl/dfrl_product.sv @@
// Rate times amount in Q16 on one shared multiplier: low rate half, high rate half, then the sum.
module dfrl_product
    import dfrl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RATE_W-1:0] i_rate,
    input  logic [MAG_W-1:0]  i_amount,
    output logic              o_done,
    output logic [PROD_W-1:0] o_product
);

    logic                 r_busy;
    t_mul_step            r_step;
    logic                 r_done;
    logic [RATE_W-1:0]    r_rate;
    logic [MAG_W-1:0]     r_amount;
    logic [PROD_W-1:0]    r_lo_part;
    logic [PROD_W-1:0]    r_hi_part;
    logic [PROD_W-1:0]    r_product;
    logic [RATE_HI_W-1:0] mul_a;
    logic [PROD_W-1:0]    mul_p;

    always_comb begin
        mul_a = (r_step == MS_LO) ? RATE_HI_W'(r_rate[FRAC_W-1:0])
                                  : r_rate[RATE_W-1:FRAC_W];
        mul_p = PROD_W'(mul_a) * PROD_W'(r_amount);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= MS_LO;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= MS_LO;
            end else if (r_busy) begin
                unique case (r_step)
                    MS_LO: begin
                        r_step <= MS_HI;
                    end
                    MS_HI: begin
                        r_step <= MS_SUM;
                    end
                    MS_SUM: begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        r_step <= MS_LO;
                    end
                    default: begin
                        r_busy <= 1'b0;
                        r_step <= MS_LO;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rate   <= i_rate;
            r_amount <= i_amount;
        end
        if (r_busy && r_step == MS_LO) begin
            r_lo_part <= mul_p;
        end
        if (r_busy && r_step == MS_HI) begin
            r_hi_part <= mul_p;
        end
        if (r_busy && r_step == MS_SUM) begin
            r_product <= r_hi_part + (r_lo_part >> FRAC_W);
        end
    end

    assign o_done    = r_done;
    assign o_product = r_product;

endmodule

@@ hw/rtl/dated_rate_floor_lookup.sv @@
// Dated rate table: sorted insert on load, binary floor search and Q16 product on query.
//
// Each input word is either a load (func 0) or a query (func 1) and yields one result word.
// Entries live in two one-read one-write RAMs of TABLE_DEPTH words, kept sorted by date key.
// A query runs a binary search, one memory read per step on the date RAM, then reads the
// rate, runs the multiply and loads the result. A bad query skips the search and goes
// straight to the result. A load searches the same way, then shifts the entries above the
// insert point up by one, one entry per cycle through the RAM read and write ports, and
// writes the new entry; replacing an existing date or hitting a full table goes from the
// search straight to the result. The next word is taken once the block is back in idle
// after the result is loaded. Only one word is in work at a time; a finished result waits
// in the output register while the next word is taken. The table needs no clearing after reset.
module dated_rate_floor_lookup
    import dfrl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_func,
    input  logic [YEAR_W-1:0]  i_year,
    input  logic [MONTH_W-1:0] i_month,
    input  logic [DAY_W-1:0]   i_day,
    input  logic [AMT_W-1:0]   i_amount_in,
    input  logic [RATE_W-1:0]  i_rate_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic               o_found,
    output logic [PROD_W-1:0]  o_product
);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_lo, n_lo;
    logic [CNT_W-1:0]   r_hi, n_hi;
    logic [CNT_W-1:0]   r_mid, n_mid;
    logic [CNT_W-1:0]   r_sh, n_sh;
    logic               r_eq, n_eq;
    t_status            r_res_status, n_res_status;
    logic               r_res_found, n_res_found;
    logic               r_out_valid, n_out_valid;
    logic [2:0]         r_out_status;
    logic               r_out_found;
    logic [PROD_W-1:0]  r_out_product;

    logic               r_func;
    logic [KEY_W-1:0]   r_key;
    logic [YEAR_W-1:0]  r_year;
    logic [MONTH_W-1:0] r_month;
    logic [DAY_W-1:0]   r_day;
    logic [AMT_W-1:0]   r_amount;
    logic [RATE_W-1:0]  r_rate;

    logic               accept;
    logic               out_load;
    t_status            chk_status;
    logic               mul_start;
    logic               mul_done;
    logic [PROD_W-1:0]  mul_product;

    logic [ADDR_W-1:0]  mem_raddr;
    logic [ADDR_W-1:0]  mem_waddr;
    logic               date_we;
    logic               rate_we;
    logic [KEY_W-1:0]   date_wdata;
    logic [RATE_W-1:0]  rate_wdata;
    logic [KEY_W-1:0]   date_rdata;
    logic [RATE_W-1:0]  rate_rdata;

    logic [CNT_W-1:0]   lo_nx;
    logic [CNT_W-1:0]   hi_nx;
    logic [CNT_W:0]     mid_sum;
    logic [CNT_W-1:0]   mid_nx;
    logic [CNT_W-1:0]   mid_inc;
    logic [CNT_W-1:0]   lo_dec;
    logic [CNT_W-1:0]   sh_inc;
    logic [CNT_W-1:0]   sh_dec;
    logic [CNT_W-1:0]   cnt_dec;
    logic [CNT_W-1:0]   cnt_half;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    assign mid_inc  = r_mid + 1'b1;
    assign lo_dec   = r_lo - 1'b1;
    assign sh_inc   = r_sh + 1'b1;
    assign sh_dec   = r_sh - 1'b1;
    assign cnt_dec  = r_count - 1'b1;
    assign cnt_half = r_count >> 1;

    dfrl_date_check u_check (
        .i_year   (r_year),
        .i_month  (r_month),
        .i_day    (r_day),
        .i_amount (r_amount),
        .o_status (chk_status)
    );

    dfrl_product u_product (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_rate    (rate_rdata),
        .i_amount  (r_amount[MAG_W-1:0]),
        .o_done    (mul_done),
        .o_product (mul_product)
    );

    dfrl_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_date_ram (
        .i_clk   (i_clk),
        .i_we    (date_we),
        .i_waddr (mem_waddr),
        .i_wdata (date_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (date_rdata)
    );

    dfrl_ram #(
        .WIDTH (RATE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_rate_ram (
        .i_clk   (i_clk),
        .i_we    (rate_we),
        .i_waddr (mem_waddr),
        .i_wdata (rate_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rate_rdata)
    );

    // Next bounds of the search from the entry read at r_mid.
    always_comb begin
        lo_nx = r_lo;
        hi_nx = r_hi;
        if (date_rdata <= r_key) begin
            lo_nx = mid_inc;
        end else begin
            hi_nx = r_mid;
        end
        mid_sum = (CNT_W + 1)'(lo_nx) + (CNT_W + 1)'(hi_nx);
        mid_nx  = mid_sum[CNT_W:1];
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_sh         = r_sh;
        n_eq         = r_eq;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_out_valid  = r_out_valid && i_out_stall;
        out_load     = 1'b0;
        mul_start    = 1'b0;
        mem_raddr    = r_mid[ADDR_W-1:0];
        mem_waddr    = r_lo[ADDR_W-1:0];
        date_we      = 1'b0;
        rate_we      = 1'b0;
        date_wdata   = r_key;
        rate_wdata   = r_rate;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_eq        = 1'b0;
                n_lo        = '0;
                n_hi        = r_count;
                n_res_found = 1'b0;
                if (r_func == FN_QUERY && chk_status != ST_OK) begin
                    n_res_status = chk_status;
                    n_state      = S_FINISH;
                end else if (r_count == '0) begin
                    n_state = S_POST;
                end else begin
                    n_mid     = cnt_half;
                    mem_raddr = cnt_half[ADDR_W-1:0];
                    n_state   = S_SEARCH;
                end
            end
            S_SEARCH: begin
                n_lo = lo_nx;
                n_hi = hi_nx;
                // the last lower-bound move decides whether the key is already stored
                if (date_rdata <= r_key) begin
                    n_eq = (date_rdata == r_key);
                end
                if (lo_nx < hi_nx) begin
                    n_mid     = mid_nx;
                    mem_raddr = mid_nx[ADDR_W-1:0];
                end else begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                n_res_status = ST_OK;
                if (r_func == FN_QUERY) begin
                    if (r_lo == '0) begin
                        n_state = S_FINISH;
                    end else begin
                        mem_raddr = lo_dec[ADDR_W-1:0];
                        n_state   = S_RATE;
                    end
                end else if (r_eq) begin
                    mem_waddr = lo_dec[ADDR_W-1:0];
                    rate_we   = 1'b1;
                    n_state   = S_FINISH;
                end else if (r_count >= DEPTH_CNT) begin
                    n_res_status = ST_FULL;
                    n_state      = S_FINISH;
                end else if (r_lo == r_count) begin
                    n_state = S_INSERT;
                end else begin
                    mem_raddr = cnt_dec[ADDR_W-1:0];
                    n_sh      = cnt_dec;
                    n_state   = S_SHIFT;
                end
            end
            S_RATE: begin
                mul_start = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                if (mul_done) begin
                    n_res_found = 1'b1;
                    n_state     = S_FINISH;
                end
            end
            S_SHIFT: begin
                // move entry r_sh up one while reading the one below it
                mem_waddr  = sh_inc[ADDR_W-1:0];
                date_we    = 1'b1;
                rate_we    = 1'b1;
                date_wdata = date_rdata;
                rate_wdata = rate_rdata;
                if (r_sh == r_lo) begin
                    n_state = S_INSERT;
                end else begin
                    mem_raddr = sh_dec[ADDR_W-1:0];
                    n_sh      = sh_dec;
                end
            end
            S_INSERT: begin
                date_we = 1'b1;
                rate_we = 1'b1;
                n_count = r_count + 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_eq        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_eq        <= n_eq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_sh         <= n_sh;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        if (accept) begin
            r_func   <= i_func;
            r_key    <= {i_year, i_month, i_day};
            r_year   <= i_year;
            r_month  <= i_month;
            r_day    <= i_day;
            r_amount <= i_amount_in;
            r_rate   <= i_rate_in;
        end
        if (out_load) begin
            r_out_status  <= r_res_status;
            r_out_found   <= r_res_found;
            r_out_product <= r_res_found ? mul_product : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_found     = r_out_found;
    assign o_product   = r_out_product;

endmodule

@@ hw/rtl/dfrl_checker.sv @@
// Port-level checks for the dated rate floor lookup, bound to the top level.
module dfrl_checker
    import dfrl_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               i_func,
    input logic [YEAR_W-1:0]  i_year,
    input logic [MONTH_W-1:0] i_month,
    input logic [DAY_W-1:0]   i_day,
    input logic [AMT_W-1:0]   i_amount_in,
    input logic [RATE_W-1:0]  i_rate_in,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [2:0]         o_status,
    input logic               o_found,
    input logic [PROD_W-1:0]  o_product
);

    // a result word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_found) && $stable(o_product))
        else $error("result word changed while stalled");

    // one word in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after an accept");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> !o_found && (o_product == '0))
        else $error("error result carries a hit or a product");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> (o_product == '0))
        else $error("product nonzero without a hit");

endmodule

bind dated_rate_floor_lookup dfrl_checker u_dfrl_checker (.*);
